[rtl/core/sacl_pkg.sv]
// shared types and constants for the set-associative cache lru tag store
// no dependencies; imported by the controller, datapath and top level
`timescale 1ns / 1ps
`default_nettype none

package sacl_pkg;

	localparam int ADDR_W    = 32;
	localparam int TAG_W     = 30;
	localparam int STAMP_W   = 32;
	localparam int COUNT_W   = 32;
	localparam int CFG_W     = 4;
	localparam int CFG_IDX_W = 2;
	localparam int WAY_OUT_W = 3;

	localparam logic [CFG_W-1:0] INDEX_BITS_RST  = 4'd10;
	localparam logic [CFG_W-1:0] OFFSET_BITS_RST = 4'd2;
	localparam logic [CFG_W-1:0] WAYS_RST        = 4'd1;
	localparam logic [CFG_W-1:0] OFFSET_BITS_MIN = 4'd2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_INDEX_BITS  = 2'd0,
		REG_OFFSET_BITS = 2'd1,
		REG_WAYS_IN_USE = 2'd2
	} cfg_reg_t;

	// one way of a set as it sits in the tag memory
	typedef struct packed {
		logic               valid;
		logic [TAG_W-1:0]   tag;
		logic [STAMP_W-1:0] stamp;
	} line_t;

	// controller to datapath
	typedef struct packed {
		logic clear_step;
		logic capture;
		logic read;
		logic eval;
		logic search_step;
		logic commit;
	} ctrl_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic clear_last;
		logic hit_now;
		logic free_now;
		logic multi_way;
		logic scan_last;
		logic out_blocked;
	} ctrl_sts_t;

endpackage

`default_nettype wire

[rtl/core/set_assoc_cache_lru_lookup_core.sv]
// Tag store of a set-associative cache with least-recently-used replacement.
// Input channel: in_valid / in_stall with a 32-bit byte address; a transfer
// happens on a rising edge with in_valid high and in_stall low.
// Output channel: out_valid / out_stall with hit, way, evicted and the
// running hit and miss totals, one result per address.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 index_bits, 1 offset_bits, 2 ways_in_use); write only while idle.
// After reset the tag memory is swept clear, one set per cycle, with in_stall
// held high; configuration writes are taken during the sweep.
// Each address passes through accept, memory read, tag compare and commit;
// a miss into a full set adds a stamp scan over the searched ways beyond
// the first (ways_in_use limited to 1..MAX_WAYS). The result is registered
// at commit, after the scan where there is one.
// A held result stalls only the commit step: the next address is accepted
// while a result waits, and is held at commit until the output frees up.
`timescale 1ns / 1ps
`default_nettype none

module set_assoc_cache_lru_lookup_core
	import sacl_pkg::*;
#(
	parameter int MAX_INDEX_BITS = 10,
	parameter int MAX_WAYS       = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [ADDR_W-1:0]    address,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      hit,
	output logic [WAY_OUT_W-1:0]      way,
	output logic                      evicted,
	output logic [COUNT_W-1:0]        hit_total,
	output logic [COUNT_W-1:0]        miss_total
);

	ctrl_cmd_t cmd;
	ctrl_sts_t sts;

	sacl_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	sacl_datapath #(
		.MAX_INDEX_BITS (MAX_INDEX_BITS),
		.MAX_WAYS       (MAX_WAYS)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.address    (address),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.hit        (hit),
		.way        (way),
		.evicted    (evicted),
		.hit_total  (hit_total),
		.miss_total (miss_total),
		.cmd        (cmd),
		.sts        (sts)
	);

endmodule

`default_nettype wire

[rtl/core/sacl_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module sacl_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                                  clk,
	input  wire logic                                  we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                      wdata,
	input  wire logic                                  re,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic      [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

[rtl/core/sacl_ctrl.sv]
// sequencing state machine for the cache tag store
// depends on sacl_pkg for the command and status structs
`timescale 1ns / 1ps
`default_nettype none

module sacl_ctrl
	import sacl_pkg::*;
(
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_stall,
	input  wire ctrl_sts_t sts,
	output ctrl_cmd_t      cmd
);

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_READ,
		ST_EVAL,
		ST_SEARCH,
		ST_COMMIT
	} state_t;

	state_t state_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_CLEAR:  cmd.clear_step  = 1'b1;
			ST_IDLE:   cmd.capture     = in_valid;
			ST_READ:   cmd.read        = 1'b1;
			ST_EVAL:   cmd.eval        = 1'b1;
			ST_SEARCH: cmd.search_step = 1'b1;
			ST_COMMIT: cmd.commit      = !sts.out_blocked;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			in_stall <= 1'b1;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (sts.clear_last) begin
						state_q  <= ST_IDLE;
						in_stall <= 1'b0;
					end
				end
				ST_IDLE: begin
					if (in_valid) begin
						state_q  <= ST_READ;
						in_stall <= 1'b1;
					end
				end
				ST_READ: begin
					state_q <= ST_EVAL;
				end
				ST_EVAL: begin
					// a miss into a full set with more than one way needs the stamp scan
					if (!sts.hit_now && !sts.free_now && sts.multi_way) begin
						state_q <= ST_SEARCH;
					end else begin
						state_q <= ST_COMMIT;
					end
				end
				ST_SEARCH: begin
					if (sts.scan_last) begin
						state_q <= ST_COMMIT;
					end
				end
				ST_COMMIT: begin
					if (!sts.out_blocked) begin
						state_q  <= ST_IDLE;
						in_stall <= 1'b0;
					end
				end
				default: begin
					state_q  <= ST_CLEAR;
					in_stall <= 1'b1;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

[rtl/core/sacl_datapath.sv]
// tag memory, address split, hit and victim selection, counters and output register
// depends on sacl_pkg and sacl_ram
`timescale 1ns / 1ps
`default_nettype none

module sacl_datapath
	import sacl_pkg::*;
#(
	parameter int MAX_INDEX_BITS = 10,
	parameter int MAX_WAYS       = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic [ADDR_W-1:0]    address,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic                      hit,
	output logic [WAY_OUT_W-1:0]      way,
	output logic                      evicted,
	output logic [COUNT_W-1:0]        hit_total,
	output logic [COUNT_W-1:0]        miss_total,
	input  wire ctrl_cmd_t            cmd,
	output ctrl_sts_t                 sts
);

	localparam int NUM_SETS = 1 << MAX_INDEX_BITS;
	localparam int SET_W    = MAX_INDEX_BITS > 0 ? MAX_INDEX_BITS : 1;
	localparam int WAY_W    = MAX_WAYS > 1 ? $clog2(MAX_WAYS) : 1;
	localparam int NW_W     = $clog2(MAX_WAYS + 1);
	localparam int LINE_W   = $bits(line_t);
	localparam int ROW_W    = LINE_W * MAX_WAYS;

	localparam logic [SET_W-1:0] SET_LAST = SET_W'(NUM_SETS - 1);

	// configuration
	logic [CFG_W-1:0] index_bits_q;
	logic [CFG_W-1:0] offset_bits_q;
	logic [CFG_W-1:0] ways_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			index_bits_q  <= INDEX_BITS_RST;
			offset_bits_q <= OFFSET_BITS_RST;
			ways_q        <= WAYS_RST;
		end else if (cfg_we) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_INDEX_BITS:  index_bits_q  <= cfg_data;
				REG_OFFSET_BITS: offset_bits_q <= cfg_data;
				REG_WAYS_IN_USE: ways_q        <= cfg_data;
				default: ;
			endcase
		end
	end

	// address split with saturated configuration
	logic [CFG_W-1:0]  ib_eff;
	logic [CFG_W-1:0]  ob_eff;
	logic [NW_W-1:0]   nw_eff;
	logic [ADDR_W-1:0] block;
	logic [ADDR_W-1:0] set_mask;
	logic [ADDR_W-1:0] set_full;
	logic [ADDR_W-1:0] tag_full;

	always_comb begin
		ib_eff = (index_bits_q > CFG_W'(MAX_INDEX_BITS)) ? CFG_W'(MAX_INDEX_BITS)
			: index_bits_q;
		ob_eff = (offset_bits_q < OFFSET_BITS_MIN) ? OFFSET_BITS_MIN : offset_bits_q;
		if (ways_q == '0) begin
			nw_eff = NW_W'(1);
		end else if ({1'b0, ways_q} > (CFG_W + 1)'(MAX_WAYS)) begin
			nw_eff = NW_W'(MAX_WAYS);
		end else begin
			nw_eff = NW_W'(ways_q);
		end
		block    = address >> ob_eff;
		set_mask = ADDR_W'((33'd1 << ib_eff) - 33'd1);
		set_full = block & set_mask;
		tag_full = block >> ib_eff;
	end

	logic [SET_W-1:0] set_q;
	logic [TAG_W-1:0] tag_q;
	logic [NW_W-1:0]  nw_q;

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			set_q <= set_full[SET_W-1:0];
			tag_q <= tag_full[TAG_W-1:0];
			nw_q  <= nw_eff;
		end
	end

	// clearing sweep after reset
	logic [SET_W-1:0] clr_addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear_step) begin
			clr_addr_q <= clr_addr_q + SET_W'(1);
		end
	end

	// tag memory, one row per set
	line_t [MAX_WAYS-1:0] row;
	line_t [MAX_WAYS-1:0] new_row;
	logic [ROW_W-1:0]     rdata;
	logic                 ram_we;
	logic [SET_W-1:0]     ram_waddr;
	logic [ROW_W-1:0]     ram_wdata;

	assign row       = rdata;
	assign ram_we    = cmd.clear_step | cmd.commit;
	assign ram_waddr = cmd.clear_step ? clr_addr_q : set_q;
	assign ram_wdata = cmd.clear_step ? '0 : ROW_W'(new_row);

	sacl_ram #(
		.WIDTH (ROW_W),
		.DEPTH (NUM_SETS)
	) u_tag_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (cmd.read),
		.raddr (set_q),
		.rdata (rdata)
	);

	// hit and free-way search, lowest way wins
	logic             hit_now;
	logic             free_now;
	logic [WAY_W-1:0] hit_way;
	logic [WAY_W-1:0] free_way;

	always_comb begin
		hit_now  = 1'b0;
		free_now = 1'b0;
		hit_way  = '0;
		free_way = '0;
		for (int w = MAX_WAYS - 1; w >= 0; w--) begin
			if (NW_W'(w) < nw_q) begin
				if (row[w].valid && row[w].tag == tag_q) begin
					hit_now = 1'b1;
					hit_way = WAY_W'(w);
				end
				if (!row[w].valid) begin
					free_now = 1'b1;
					free_way = WAY_W'(w);
				end
			end
		end
	end

	// victim scan over stamps, one way per cycle
	logic             hit_q;
	logic             evict_q;
	logic [WAY_W-1:0] pick_q;
	logic [WAY_W-1:0] scan_q;

	always_ff @(posedge clk) begin
		if (cmd.eval) begin
			hit_q   <= hit_now;
			evict_q <= !hit_now && !free_now;
			pick_q  <= hit_now ? hit_way : (free_now ? free_way : '0);
			scan_q  <= WAY_W'(1);
		end else if (cmd.search_step) begin
			if (row[scan_q].stamp < row[pick_q].stamp) begin
				pick_q <= scan_q;
			end
			scan_q <= scan_q + WAY_W'(1);
		end
	end

	// counters
	logic [STAMP_W-1:0] access_q;
	logic [COUNT_W-1:0] hit_cnt_q;
	logic [COUNT_W-1:0] miss_cnt_q;
	logic [STAMP_W-1:0] stamp_next;
	logic [COUNT_W-1:0] hit_cnt_next;
	logic [COUNT_W-1:0] miss_cnt_next;

	assign stamp_next    = access_q + STAMP_W'(1);
	assign hit_cnt_next  = hit_cnt_q + COUNT_W'(hit_q);
	assign miss_cnt_next = miss_cnt_q + COUNT_W'(!hit_q);

	always_comb begin
		new_row               = row;
		new_row[pick_q].valid = 1'b1;
		new_row[pick_q].tag   = tag_q;
		new_row[pick_q].stamp = stamp_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			access_q   <= '0;
			hit_cnt_q  <= '0;
			miss_cnt_q <= '0;
		end else if (cmd.commit) begin
			access_q   <= stamp_next;
			hit_cnt_q  <= hit_cnt_next;
			miss_cnt_q <= miss_cnt_next;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (cmd.commit) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			hit        <= hit_q;
			way        <= WAY_OUT_W'(pick_q);
			evicted    <= evict_q;
			hit_total  <= hit_cnt_next;
			miss_total <= miss_cnt_next;
		end
	end

	always_comb begin
		sts             = '0;
		sts.clear_last  = clr_addr_q == SET_LAST;
		sts.hit_now     = hit_now;
		sts.free_now    = free_now;
		sts.multi_way   = nw_q > NW_W'(1);
		sts.scan_last   = NW_W'(scan_q) == (nw_q - NW_W'(1));
		sts.out_blocked = out_valid && out_stall;
	end

`ifndef SYNTHESIS
	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command at once");

	a_commit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> !(out_valid && out_stall))
		else $error("result committed over a stalled result");

	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(hit && evicted))
		else $error("hit reported together with an eviction");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> (hit_cnt_q + miss_cnt_q) == ($past(hit_cnt_q + miss_cnt_q) + COUNT_W'(1)))
		else $error("hit and miss counts did not advance by one");
`endif

endmodule

`default_nettype wire

[tb/sv/sacl_lookup_checker.sv]
`timescale 1ns / 1ps
// lookup checker for the set-associative lru tag store: follows register writes, predicts
// every lookup result and compares each output transfer field by field; depends on sacl_pkg

module sacl_lookup_checker
	import sacl_pkg::*;
#(
	parameter int MAX_INDEX_BITS = 10,
	parameter int MAX_WAYS       = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 in_valid,
	input  logic                 in_stall,
	input  logic [ADDR_W-1:0]    address,
	input  logic                 out_valid,
	input  logic                 out_stall,
	input  logic                 hit,
	input  logic [WAY_OUT_W-1:0] way,
	input  logic                 evicted,
	input  logic [COUNT_W-1:0]   hit_total,
	input  logic [COUNT_W-1:0]   miss_total,
	output int                   mismatch_count,
	output int                   results_pending,
	output int                   lookups_checked,
	output int                   hits_seen,
	output int                   evictions_seen
);

	localparam int NUM_LINES = (1 << MAX_INDEX_BITS) * MAX_WAYS;

	typedef struct packed {
		logic                 hit;
		logic [WAY_OUT_W-1:0] way;
		logic                 evicted;
		logic [COUNT_W-1:0]   hit_total;
		logic [COUNT_W-1:0]   miss_total;
	} lookup_result_t;

	logic [CFG_W-1:0]   set_bits_reg;
	logic [CFG_W-1:0]   offset_bits_reg;
	logic [CFG_W-1:0]   ways_reg;
	logic               slot_valid [NUM_LINES];
	logic [TAG_W-1:0]   slot_tag   [NUM_LINES];
	logic [STAMP_W-1:0] slot_stamp [NUM_LINES];
	logic [STAMP_W-1:0] access_count;
	logic [COUNT_W-1:0] hit_count;
	logic [COUNT_W-1:0] miss_count;
	lookup_result_t     expected_lookups [$];

	task automatic check_field(input string field, input logic [31:0] want,
		input logic [31:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
			mismatch_count++;
		end
	endtask

	// one lookup against the tag store, updating stamps, lines and totals
	function automatic lookup_result_t predict_lookup(input logic [ADDR_W-1:0] addr);
		int unsigned       ib;
		int unsigned       ob;
		int unsigned       nw;
		int unsigned       base;
		int unsigned       pick;
		int unsigned       w;
		logic [ADDR_W-1:0] block;
		logic [ADDR_W-1:0] set_no;
		logic [TAG_W-1:0]  tag;
		bit                found;
		lookup_result_t    res;

		ib = (set_bits_reg > MAX_INDEX_BITS) ? MAX_INDEX_BITS : set_bits_reg;
		ob = (offset_bits_reg < OFFSET_BITS_MIN) ? OFFSET_BITS_MIN : offset_bits_reg;
		nw = (ways_reg == 0) ? 1 : ((ways_reg > MAX_WAYS) ? MAX_WAYS : ways_reg);
		res = '0;
		pick = 0;
		found = 1'b0;
		access_count++;
		block = addr >> ob;
		set_no = block & ((32'd1 << ib) - 32'd1);
		tag = TAG_W'(block >> ib);
		base = set_no * MAX_WAYS;

		for (w = 0; w < nw; w++) begin
			if (!res.hit && slot_valid[base + w] && slot_tag[base + w] == tag) begin
				res.hit = 1'b1;
				pick = w;
			end
		end

		if (res.hit) begin
			slot_stamp[base + pick] = access_count;
			hit_count++;
		end else begin
			miss_count++;
			for (w = 0; w < nw; w++) begin
				if (!found && !slot_valid[base + w]) begin
					found = 1'b1;
					pick = w;
				end
			end
			// full set: oldest stamp goes, lowest way on a tie
			if (!found) begin
				pick = 0;
				for (w = 1; w < nw; w++) begin
					if (slot_stamp[base + w] < slot_stamp[base + pick])
						pick = w;
				end
				res.evicted = 1'b1;
			end
			slot_valid[base + pick] = 1'b1;
			slot_tag[base + pick] = tag;
			slot_stamp[base + pick] = access_count;
		end

		res.way = pick[WAY_OUT_W-1:0];
		res.hit_total = hit_count;
		res.miss_total = miss_count;
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin : lookup_watch
		lookup_result_t want;
		if (!arst_n) begin
			set_bits_reg = INDEX_BITS_RST;
			offset_bits_reg = OFFSET_BITS_RST;
			ways_reg = WAYS_RST;
			for (int i = 0; i < NUM_LINES; i++) begin
				slot_valid[i] = 1'b0;
				slot_tag[i] = '0;
				slot_stamp[i] = '0;
			end
			access_count = '0;
			hit_count = '0;
			miss_count = '0;
			expected_lookups.delete();
			mismatch_count = 0;
			lookups_checked = 0;
			hits_seen = 0;
			evictions_seen = 0;
			results_pending <= 0;
		end else begin
			// a result leaves only after its address was taken, so pop first
			if (out_valid && !out_stall) begin
				if (expected_lookups.size() == 0) begin
					$display("%0t ns: result transfer with none expected, actual hit %0b way %0d evicted %0b hits %0d misses %0d",
						$time, hit, way, evicted, hit_total, miss_total);
					mismatch_count++;
				end else begin
					want = expected_lookups.pop_front();
					check_field("hit", want.hit, hit);
					check_field("way", want.way, way);
					check_field("evicted", want.evicted, evicted);
					check_field("hit_total", want.hit_total, hit_total);
					check_field("miss_total", want.miss_total, miss_total);
					lookups_checked++;
					if (hit === 1'b1)
						hits_seen++;
					if (evicted === 1'b1)
						evictions_seen++;
				end
			end
			if (cfg_we) begin
				case (cfg_index)
				REG_INDEX_BITS:  set_bits_reg = cfg_data;
				REG_OFFSET_BITS: offset_bits_reg = cfg_data;
				REG_WAYS_IN_USE: ways_reg = cfg_data;
				default:         ;
				endcase
			end
			if (in_valid && !in_stall)
				expected_lookups.push_back(predict_lookup(address));
			results_pending <= expected_lookups.size();
		end
	end

endmodule

[tb/sv/tb_set_assoc_cache_lru_lookup_core.sv]
`timescale 1ns / 1ps
// testbench top for the set-associative lru tag store: drives register writes and address
// transfers with bursty sending and patterned output stall; uses sacl_pkg and sacl_lookup_checker

module tb_set_assoc_cache_lru_lookup_core;
	import sacl_pkg::*;

	localparam int INDEX_BITS_CAP = 10;
	localparam int WAYS_CAP       = 8;
	localparam int PHASES         = 12;
	localparam int PHASE_ITEMS    = 158;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]     cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic [ADDR_W-1:0]    address = '0;
	logic                 out_stall = 1'b0;
	logic                 in_stall;
	logic                 out_valid;
	logic                 hit;
	logic [WAY_OUT_W-1:0] way;
	logic                 evicted;
	logic [COUNT_W-1:0]   hit_total;
	logic [COUNT_W-1:0]   miss_total;
	int                   mismatch_count;
	int                   results_pending;
	int                   lookups_checked;
	int                   hits_seen;
	int                   evictions_seen;

	// stimulus shaping for the current setting
	int unsigned      use_ib;
	int unsigned      use_ob;
	int unsigned      use_nw;
	int unsigned      set_base;
	int unsigned      pool_size;
	logic [TAG_W-1:0] tag_pool [16];
	int unsigned      burst_left = 0;
	int unsigned      stall_left = 0;
	stall_mode_t      stall_mode = STALL_NONE;

	set_assoc_cache_lru_lookup_core #(
		.MAX_INDEX_BITS(INDEX_BITS_CAP),
		.MAX_WAYS(WAYS_CAP)
	) dut (.*);

	sacl_lookup_checker #(
		.MAX_INDEX_BITS(INDEX_BITS_CAP),
		.MAX_WAYS(WAYS_CAP)
	) checker_i (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		#(5_000_000);
		$display("tb_set_assoc_cache_lru_lookup_core failed");
		$finish;
	end

	// receiver stalls in one of four modes, a new one picked at random whenever the current run ends
	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_mode = stall_mode_t'($urandom_range(0, 3));
			stall_left = $urandom_range(16, 256);
		end
		stall_left--;
		case (stall_mode)
		STALL_NONE:  out_stall <= 1'b0;
		STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
		STALL_HEAVY: out_stall <= ($urandom_range(0, 3) != 0);
		default:     out_stall <= (stall_left % 7) < 3;
		endcase
	end

	task automatic send_address(input logic [ADDR_W-1:0] addr);
		int unsigned gap;
		address <= addr;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall !== 1'b0);
		if (burst_left > 1) begin
			burst_left--;
		end else begin
			burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 160) : $urandom_range(1, 8);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	task automatic hold_until_drained();
		in_valid <= 1'b0;
		do @(posedge clk); while (results_pending != 0);
	endtask

	task automatic note_setting(input logic [CFG_W-1:0] ib, input logic [CFG_W-1:0] ob,
		input logic [CFG_W-1:0] nw);
		use_ib = (ib > INDEX_BITS_CAP) ? INDEX_BITS_CAP : ib;
		use_ob = (ob < OFFSET_BITS_MIN) ? OFFSET_BITS_MIN : ob;
		use_nw = (nw == 0) ? 1 : ((nw > WAYS_CAP) ? WAYS_CAP : nw);
		set_base = $urandom;
		// a few more tags than ways so the sets both hit and thrash
		pool_size = use_nw + $urandom_range(1, 3);
		for (int i = 0; i < 16; i++)
			tag_pool[i] = TAG_W'($urandom);
	endtask

	task automatic apply_setting(input logic [CFG_W-1:0] ib, input logic [CFG_W-1:0] ob,
		input logic [CFG_W-1:0] nw, input bit poke_unused);
		cfg_we <= 1'b1;
		if (poke_unused) begin
			cfg_index <= REG_UNUSED;
			cfg_data <= CFG_W'($urandom);
			@(posedge clk);
		end
		cfg_index <= REG_INDEX_BITS;
		cfg_data <= ib;
		@(posedge clk);
		cfg_index <= REG_OFFSET_BITS;
		cfg_data <= ob;
		@(posedge clk);
		cfg_index <= REG_WAYS_IN_USE;
		cfg_data <= nw;
		@(posedge clk);
		cfg_we <= 1'b0;
		note_setting(ib, ob, nw);
	endtask

	// mostly addresses from a small tag pool over a few neighboring sets
	function automatic logic [ADDR_W-1:0] pick_address();
		logic [63:0] composed;
		int unsigned set_no;
		if ($urandom_range(0, 4) == 0)
			return $urandom;
		set_no = (set_base + $urandom_range(0, 2)) & ((1 << use_ib) - 1);
		composed = 64'(tag_pool[$urandom_range(0, pool_size - 1)]);
		composed = (composed << use_ib) | 64'(set_no);
		composed = (composed << use_ob) | 64'($urandom & ((1 << use_ob) - 1));
		return composed[ADDR_W-1:0];
	endfunction

	function automatic logic [3*CFG_W-1:0] phase_setting(input int p);
		case (p)
		0:       return {4'd0, 4'd2, 4'd8};
		1:       return {4'd10, 4'd8, 4'd8};
		2:       return {4'd15, 4'd0, 4'd15};
		3:       return {4'd4, 4'd15, 4'd0};
		4:       return {4'd1, 4'd3, 4'd2};
		5:       return {4'd3, 4'd5, 4'd3};
		6:       return {4'd2, 4'd2, 4'd8};
		7:       return {4'd5, 4'd7, 4'd5};
		8:       return {4'd0, 4'd8, 4'd1};
		9:       return {4'd6, 4'd6, 4'd7};
		default: return (3*CFG_W)'($urandom);
		endcase
	endfunction

	initial begin : stimulus
		logic [3*CFG_W-1:0] setting;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		note_setting(INDEX_BITS_RST, OFFSET_BITS_RST, WAYS_RST);

		// reset setting, direct mapped: fill, hit within the block, conflict evictions
		send_address(32'h0000_0000);
		send_address(32'h0000_0003);
		send_address(32'hFFFF_FFFF);
		send_address(32'hFFFF_FFFC);
		send_address(32'h0000_1000);
		send_address(32'h0000_0000);
		hold_until_drained();

		// four ways over four sets; the old line at address zero stays and hits
		apply_setting(4'd2, 4'd2, 4'd4, 1'b1);
		send_address(32'h0000_0000);
		send_address(32'h0000_0010);
		send_address(32'h0000_0020);
		send_address(32'h0000_0030);
		send_address(32'h0000_0014);
		send_address(32'h0000_0040);
		send_address(32'h0000_0000);
		send_address(32'hFFFF_FFFF);
		send_address(32'h8000_0000);
		hold_until_drained();

		// index bits and ways above their range, offset bits below it
		apply_setting(4'd15, 4'd0, 4'd15, 1'b0);
		send_address(32'h0000_0000);
		send_address(32'h0000_0004);
		send_address(32'h0000_0040);
		send_address(32'h0000_1000);
		send_address(32'h0000_2000);
		hold_until_drained();

		// single set, widest offset, zero ways
		apply_setting(4'd0, 4'd15, 4'd0, 1'b0);
		send_address(32'h0000_0000);
		send_address(32'h0000_7FFF);
		send_address(32'h0000_8000);
		send_address(32'hFFFF_FFFF);
		hold_until_drained();

		for (int p = 0; p < PHASES; p++) begin
			setting = phase_setting(p);
			apply_setting(setting[3*CFG_W-1:2*CFG_W], setting[2*CFG_W-1:CFG_W],
				setting[CFG_W-1:0], (p % 4) == 3);
			repeat (PHASE_ITEMS)
				send_address(pick_address());
			hold_until_drained();
		end

		repeat (20) @(posedge clk);
		$display("checked %0d lookups over %0d register settings", lookups_checked, PHASES + 4);
		$display("hits %0d, misses %0d, evictions %0d", hits_seen,
			lookups_checked - hits_seen, evictions_seen);
		if (mismatch_count == 0 && results_pending == 0)
			$display("tb_set_assoc_cache_lru_lookup_core passed");
		else
			$display("tb_set_assoc_cache_lru_lookup_core failed");
		$finish;
	end

endmodule

[filelist.f]
rtl/core/sacl_pkg.sv
rtl/core/sacl_ram.sv
rtl/core/sacl_ctrl.sv
rtl/core/sacl_datapath.sv
rtl/core/set_assoc_cache_lru_lookup_core.sv
tb/sv/sacl_lookup_checker.sv
tb/sv/tb_set_assoc_cache_lru_lookup_core.sv
